### design/multi_percentile_stream_selector_unit_macros.svh
// assertion macros shared by the percentile selector rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef MULTI_PERCENTILE_STREAM_SELECTOR_UNIT_MACROS_SVH
`define MULTI_PERCENTILE_STREAM_SELECTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MPSS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MPSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mpss_pkg.sv
// shared types and constants of the percentile selector
// no dependencies
`default_nettype none

package mpss_pkg;

    localparam int FRAC_W     = 17;
    localparam int PROP_W     = 16;
    localparam int REQ_IDX_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int REQ_CNT_W  = 5;
    localparam int CFG_ADDR_W = 2;

    localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NULL_DATA = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REQS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_EVAL,
        ST_SEND
    } mpss_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic pick;
        logic eval;
        logic send;
        logic finish;
    } mpss_cmd_t;

    typedef struct packed {
        logic ignore_data;
        logic scan_done;
        logic any_match;
        logic out_free;
    } mpss_stat_t;

endpackage

`default_nettype wire

### design/mpss_ctrl.sv
// controller state machine of the percentile selector
// depends on mpss_pkg
`default_nettype none

module mpss_ctrl
    import mpss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_op,
    input  wire mpss_stat_t stat,
    output logic            s_tready,
    output mpss_cmd_t       cmd
);

    mpss_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_op == OP_DATA && !stat.ignore_data) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                state_next = stat.any_match ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (stat.out_free) begin
                    state_next = ST_PICK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid && s_op == OP_LOAD;
                cmd.start = s_tvalid && s_op == OP_DATA && !stat.ignore_data;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_PICK: begin
                cmd.pick   = stat.any_match;
                cmd.finish = !stat.any_match;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_SEND: begin
                cmd.send = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/mpss_datapath.sv
// datapath of the percentile selector: config, request table, target scan,
// answer evaluation and output register; depends on mpss_pkg
`default_nettype none

module mpss_datapath
    import mpss_pkg::*;
#(
    parameter int MAX_REQUESTS = 16,
    parameter int ROW_BITS     = 20,
    parameter int VALUE_BITS   = 32,
    localparam int RC_W        = ROW_BITS + 1,
    localparam int OUT_W       = ((REQ_IDX_W + VALUE_BITS + STATUS_W + 7) / 8) * 8
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mpss_cmd_t             cmd,
    output mpss_stat_t                 stat,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [RC_W-1:0]       cfg_data,
    input  wire logic [FRAC_W-1:0]     in_fraction,
    input  wire logic                  in_fraction_is_null,
    input  wire logic [VALUE_BITS-1:0] in_data_value,
    input  wire logic                  in_data_is_null,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tlast
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int LIM_W = (CNT_W > REQ_CNT_W) ? CNT_W : REQ_CNT_W;
    localparam int MUL_W = FRAC_W + RC_W;
    localparam int CMP_W = RC_W + 2;
    localparam int V     = VALUE_BITS;
    localparam int PAD_W = OUT_W - (REQ_IDX_W + V + STATUS_W);

    // configuration
    logic            cont_reg;
    logic [RC_W-1:0] row_count_reg;
    logic [REQ_CNT_W-1:0] req_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_reg      <= 1'b1;
            row_count_reg <= RC_W'(1);
            req_count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_MODE: cont_reg <= cfg_data[0];
                CFG_ROWS: begin
                    if (cfg_data[ROW_BITS] && (|cfg_data[ROW_BITS-1:0])) begin
                        row_count_reg <= {1'b1, {ROW_BITS{1'b0}}};
                    end else begin
                        row_count_reg <= cfg_data;
                    end
                end
                CFG_REQS: req_count_reg <= cfg_data[REQ_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // batch state
    logic [CNT_W-1:0] loaded_reg;
    logic [RC_W-1:0]  rows_seen_reg;
    logic [V-1:0]     held_value_reg;
    logic             held_null_reg;
    logic [V-1:0]     cur_value_reg;
    logic             cur_null_reg;
    logic [RC_W-1:0]  row_reg;

    logic [LIM_W-1:0] req_ext, limit, loaded_ext;
    logic [IDX_W-1:0] load_addr;
    logic             load_ok;

    always_comb begin
        req_ext    = LIM_W'(req_count_reg);
        limit      = (req_ext < LIM_W'(MAX_REQUESTS)) ? req_ext : LIM_W'(MAX_REQUESTS);
        loaded_ext = (rows_seen_reg != '0) ? '0 : LIM_W'(loaded_reg);
        load_ok    = loaded_ext < limit;
        load_addr  = loaded_ext[IDX_W-1:0];
    end

    logic [FRAC_W-1:0] frac_mem [MAX_REQUESTS];
    logic              fnull_mem[MAX_REQUESTS];
    logic [PROP_W-1:0] prop_mem [MAX_REQUESTS];

    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            frac_mem[load_addr]  <= in_fraction;
            fnull_mem[load_addr] <= in_fraction_is_null;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg     <= '0;
            rows_seen_reg  <= '0;
            held_value_reg <= '0;
            held_null_reg  <= 1'b0;
        end else if (cmd.load) begin
            if (rows_seen_reg != '0) begin
                rows_seen_reg  <= '0;
                held_value_reg <= '0;
                held_null_reg  <= 1'b0;
            end
            loaded_reg <= load_ok ? CNT_W'(loaded_ext + LIM_W'(1)) : CNT_W'(loaded_ext);
        end else if (cmd.finish) begin
            rows_seen_reg  <= row_reg;
            held_value_reg <= cur_value_reg;
            held_null_reg  <= cur_null_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_value_reg <= in_data_value;
            cur_null_reg  <= in_data_is_null;
            row_reg       <= rows_seen_reg + RC_W'(1);
        end
    end

    // shared table read port: scan address or picked request
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  pick_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [FRAC_W-1:0] rd_frac_reg;
    logic              rd_null_reg;
    logic [PROP_W-1:0] rd_prop_reg;

    assign rd_addr = cmd.pick ? pick_idx : scan_idx_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        rd_frac_reg <= frac_mem[rd_addr];
        rd_null_reg <= fnull_mem[rd_addr];
        rd_prop_reg <= prop_mem[rd_addr];
    end

    // scan pipeline: issue, multiply, classify
    logic             issue;
    logic             a_valid_reg, b_valid_reg;
    logic [IDX_W-1:0] a_idx_reg, b_idx_reg;
    logic             b_front_reg;
    logic [MUL_W-1:0] b_prod_reg;
    logic [RC_W-1:0]  n_scale;

    assign issue   = cmd.scan && (scan_idx_reg < loaded_reg);
    assign n_scale = cont_reg ? row_count_reg - RC_W'(1) : row_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end else if (cmd.start) begin
            scan_idx_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end else begin
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg   <= scan_idx_reg[IDX_W-1:0];
        b_idx_reg   <= a_idx_reg;
        b_front_reg <= rd_null_reg || (rd_frac_reg > Q16_ONE) || (row_count_reg == '0);
        b_prod_reg  <= MUL_W'(rd_frac_reg) * MUL_W'(n_scale);
    end

    logic [PROP_W-1:0] c_prop;
    logic [CMP_W-1:0]  c_row, c_first, c_second, c_k, c_disc;
    logic [MUL_W:0]    c_round;
    logic              c_m0, c_m1, c_m2;

    always_comb begin
        c_prop   = b_prod_reg[PROP_W-1:0];
        c_row    = CMP_W'(row_reg);
        c_first  = CMP_W'(b_prod_reg[MUL_W-1:PROP_W]) + CMP_W'(1);
        c_second = c_first + CMP_W'(c_prop != '0);
        c_round  = {1'b0, b_prod_reg} + (MUL_W+1)'(16'hFFFF);
        c_k      = CMP_W'(c_round[MUL_W:PROP_W]);
        c_disc   = (c_k == '0) ? CMP_W'(1) : c_k;
        c_m0 = 1'b0;
        c_m1 = 1'b0;
        c_m2 = 1'b0;
        if (b_front_reg) begin
            c_m0 = (row_reg == RC_W'(1));
        end else if (!cont_reg) begin
            c_m2 = (c_disc == c_row);
        end else if (c_second == c_row) begin
            // interpolating ones sort ahead of exact hits on this row
            c_m1 = (c_prop != '0);
            c_m2 = (c_prop == '0);
        end
    end

    logic [MAX_REQUESTS-1:0] vec0_reg, vec1_reg, vec2_reg;
    logic [MAX_REQUESTS-1:0] sel_vec, left0, left1, left2;
    logic                    sel0, sel1;

    always_comb begin
        sel0    = |vec0_reg;
        sel1    = !sel0 && (|vec1_reg);
        sel_vec = sel0 ? vec0_reg : (sel1 ? vec1_reg : vec2_reg);
        pick_idx = '0;
        for (int i = MAX_REQUESTS - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                pick_idx = IDX_W'(i);
            end
        end
        left0 = vec0_reg;
        left1 = vec1_reg;
        left2 = vec2_reg;
        if (sel0) begin
            left0[pick_idx] = 1'b0;
        end else if (sel1) begin
            left1[pick_idx] = 1'b0;
        end else begin
            left2[pick_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec0_reg <= '0;
            vec1_reg <= '0;
            vec2_reg <= '0;
        end else if (cmd.start) begin
            vec0_reg <= '0;
            vec1_reg <= '0;
            vec2_reg <= '0;
        end else if (b_valid_reg) begin
            vec0_reg[b_idx_reg] <= c_m0;
            vec1_reg[b_idx_reg] <= c_m1;
            vec2_reg[b_idx_reg] <= c_m2;
        end else if (cmd.pick) begin
            vec0_reg <= left0;
            vec1_reg <= left1;
            vec2_reg <= left2;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            prop_mem[b_idx_reg] <= c_prop;
        end
    end

    // pick and evaluate one answer
    logic [IDX_W-1:0] p_idx_reg;
    logic             p_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            p_idx_reg  <= pick_idx;
            p_last_reg <= !(|(left0 | left1 | left2));
        end
    end

    logic [V:0]          e_diff;
    logic                e_up;
    logic [STATUS_W-1:0] e_status;
    logic                e_lerp;

    always_comb begin
        e_up   = $signed(cur_value_reg) >= $signed(held_value_reg);
        e_diff = {cur_value_reg[V-1], cur_value_reg} - {held_value_reg[V-1], held_value_reg};
        e_lerp = 1'b0;
        priority if (rd_null_reg) begin
            e_status = STAT_NULL;
        end else if (rd_frac_reg > Q16_ONE) begin
            e_status = STAT_RANGE;
        end else if (row_count_reg == '0) begin
            e_status = STAT_NULL;
        end else if (!cont_reg) begin
            e_status = cur_null_reg ? STAT_NULL : STAT_OK;
        end else if (rd_prop_reg != '0) begin
            e_status = (cur_null_reg || held_null_reg) ? STAT_NULL_DATA : STAT_OK;
            e_lerp   = 1'b1;
        end else begin
            e_status = cur_null_reg ? STAT_NULL_DATA : STAT_OK;
        end
    end

    logic [V:0]            x_mag_reg;
    logic                  x_up_reg, x_lerp_reg, x_last_reg;
    logic [PROP_W-1:0]     x_prop_reg;
    logic [STATUS_W-1:0]   x_status_reg;
    logic [REQ_IDX_W-1:0]  x_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            x_mag_reg    <= e_up ? e_diff : (V+1)'(0) - e_diff;
            x_up_reg     <= e_up;
            x_lerp_reg   <= e_lerp;
            x_last_reg   <= p_last_reg;
            x_prop_reg   <= rd_prop_reg;
            x_status_reg <= e_status;
            x_idx_reg    <= REQ_IDX_W'(p_idx_reg);
        end
    end

    // interpolation and output register
    logic [V+PROP_W:0]   x_prod;
    logic [V+PROP_W+1:0] x_prod_up;
    logic [V-1:0]        x_q, x_answer;

    always_comb begin
        x_prod    = (V+PROP_W+1)'(x_mag_reg) * (V+PROP_W+1)'(x_prop_reg);
        x_prod_up = {1'b0, x_prod} + (V+PROP_W+2)'(16'hFFFF);
        x_q       = x_up_reg ? x_prod[V+PROP_W-1:PROP_W] : x_prod_up[V+PROP_W-1:PROP_W];
        if (x_status_reg != STAT_OK) begin
            x_answer = '0;
        end else if (!x_lerp_reg) begin
            x_answer = cur_value_reg;
        end else if (x_up_reg) begin
            x_answer = held_value_reg + x_q;
        end else begin
            x_answer = held_value_reg - x_q;
        end
    end

    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;
    logic                 m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.send) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.send) begin
            m_data_reg <= {{PAD_W{1'b0}}, x_status_reg, x_answer, x_idx_reg};
            m_last_reg <= x_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        stat.ignore_data = !(rows_seen_reg == '0 || rows_seen_reg < row_count_reg);
        stat.scan_done   = !(scan_idx_reg < loaded_reg) && !a_valid_reg && !b_valid_reg;
        stat.any_match   = |(vec0_reg | vec1_reg | vec2_reg);
        stat.out_free    = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

### design/multi_percentile_stream_selector_unit.sv
// top level of the multi-percentile selector over a sorted value stream
// depends on mpss_pkg, mpss_ctrl, mpss_datapath and the assertion macros
//
// a batch of percentile requests (q16 fraction or null) is loaded first, one
// per transaction with tuser op = 0, then the ascending sorted values follow
// with op = 1. for every value the block finds the requests whose last needed
// row has been reached and returns each as one result transaction: load index,
// answer and status, ordered by (low row, high row, load index), with tlast on
// the final result of that value. continuous mode interpolates between the
// previous and the current value. loads are taken back to back. a data value
// is accepted, then the target scan runs (one request per cycle through the
// shared q16 multiplier and row compare), then every result it causes passes
// the pick, evaluate and send states, and a closing pick ends the value; only
// then is the next transaction taken, and a stall on the result side delays it.
// configuration writes are always taken and must only arrive while the block
// is idle.
`default_nettype none
`include "multi_percentile_stream_selector_unit_macros.svh"

module multi_percentile_stream_selector_unit
    import mpss_pkg::*;
#(
    parameter int MAX_REQUESTS = 16,
    parameter int ROW_BITS     = 20,
    parameter int VALUE_BITS   = 32,
    localparam int IN_W        = ((FRAC_W + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((REQ_IDX_W + VALUE_BITS + STATUS_W + 7) / 8) * 8
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ROW_BITS:0]     cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,  // fraction, data_value, zero pad
    input  wire logic [2:0]            s_tuser,  // op, fraction_is_null, data_is_null
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,  // request_index, answer, status, zero pad
    output logic                       m_tlast   // last
);

    mpss_cmd_t  cmd;
    mpss_stat_t stat;

    // config registers never back-pressure
    assign cfg_ready = 1'b1;

    mpss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mpss_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .ROW_BITS     (ROW_BITS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_valid           (cfg_valid),
        .cfg_addr            (cfg_addr),
        .cfg_data            (cfg_data),
        .in_fraction         (s_tdata[FRAC_W-1:0]),
        .in_fraction_is_null (s_tuser[1]),
        .in_data_value       (s_tdata[FRAC_W+VALUE_BITS-1:FRAC_W]),
        .in_data_is_null     (s_tuser[2]),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tlast             (m_tlast)
    );

    // a result is only launched into a free output register
    `MPSS_ASSERT_IMPLY(a_send_free, aclk, aresetn, cmd.send, stat.out_free, "send into busy output")
    // a pick needs a pending match
    `MPSS_ASSERT_IMPLY(a_pick_match, aclk, aresetn, cmd.pick, stat.any_match, "pick without match")
    // a started value closes the input until its last result is launched
    `MPSS_ASSERT_NEXT(a_busy_after_start, aclk, aresetn, cmd.start, !s_tready, "input open during scan")
    // controller issues at most one command at a time
    `MPSS_ASSERT_IMPLY(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd), "overlapping commands")

endmodule

`default_nettype wire

### tb/multi_percentile_stream_selector_unit_test.sv
// self-checking testbench of the multi-percentile stream selector
// depends on mpss_pkg and multi_percentile_stream_selector_unit
`default_nettype none

module multi_percentile_stream_selector_unit_test;
    import mpss_pkg::*;

    localparam int  MAX_REQ     = 16;
    localparam int  ROW_SAT     = 1 << 20;
    localparam int  DRAIN_WAIT  = 90;    // scan of 16 requests plus a few results
    localparam int  STALL_LIMIT = 5000;
    localparam int  RANDOM_ITEMS = 345;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] ans;
        logic [1:0]  stat;
        logic        last;
    } answer_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // one row of the directed table; a typed row carries its single answer
    typedef struct {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [20:0]            cfg_val;
        logic                   op;
        logic [16:0]            frac;
        logic                   fnull;
        logic [31:0]            val;
        logic                   dnull;
        logic                   typed;
        answer_t                want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [20:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // fraction, data_value, zero pad
    logic [2:0]  s_tuser = '0;   // op, fraction_is_null, data_is_null
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // request_index, answer, status, zero pad
    logic        m_tlast;

    multi_percentile_stream_selector_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the block: registers, request table and stream position
    logic              sh_mode = 1'b1;
    longint unsigned   sh_rows = 1;
    logic [4:0]        sh_reqs = '0;
    logic [16:0]       sh_frac [MAX_REQ];
    logic              sh_fnull [MAX_REQ];
    int                sh_loaded = 0;
    longint unsigned   sh_seen = 0;
    logic [31:0]       sh_held = '0;
    logic              sh_held_null = 1'b0;

    answer_t pending_answers[$];
    bit      failed = 1'b0;
    int      phase = 0;          // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int      quiet_cycles = 0;

    // target rows of one request: first row, second row, q16 proportion
    task automatic plan_rows(input int q, output longint unsigned f,
                             output longint unsigned s, output longint unsigned p);
        longint unsigned t, k;
        f = 0; s = 0; p = 0;
        if (sh_fnull[q] || sh_frac[q] > Q16_ONE || sh_rows == 0) return;
        if (sh_mode) begin
            t = longint'(sh_frac[q]) * (sh_rows - 1);
            p = t & 64'hFFFF;
            f = 1 + (t >> 16);
            s = f + (p != 0 ? 1 : 0);
        end else begin
            k = (longint'(sh_frac[q]) * sh_rows + 65535) >> 16;
            f = (k < 1) ? 1 : k;
        end
    endtask

    // updates the shadow for one accepted transaction, returns its answers
    task automatic predict_answers(input logic op, input logic [16:0] frac, input logic fnull,
                                   input logic [31:0] val, input logic dnull,
                                   ref answer_t got[$]);
        int              lim, n, hits;
        int              ord [MAX_REQ];
        longint unsigned kf [MAX_REQ], ks [MAX_REQ], kp [MAX_REQ];
        longint unsigned r, f, s, p, done;
        longint          lo, hi;
        answer_t         a;
        int              tmp;
        got.delete();
        if (op == OP_LOAD) begin
            if (sh_seen > 0) begin
                // load after data opens a new batch
                sh_loaded = 0; sh_seen = 0; sh_held = '0; sh_held_null = 1'b0;
            end
            lim = (sh_reqs < MAX_REQ) ? sh_reqs : MAX_REQ;
            if (sh_loaded < lim) begin
                sh_frac[sh_loaded] = frac;
                sh_fnull[sh_loaded] = fnull;
                sh_loaded++;
            end
            return;
        end
        if (!(sh_seen == 0 || sh_seen < sh_rows)) return;
        r = sh_seen + 1;
        n = sh_loaded;
        hits = 0;
        for (int i = 0; i < n; i++) begin
            plan_rows(i, f, s, p);
            done = sh_mode ? s : f;
            if (done == r || (done == 0 && r == 1)) begin
                ord[hits] = i; kf[i] = f; ks[i] = s; kp[i] = p;
                hits++;
            end
        end
        // order by low row, high row, load index
        for (int i = 1; i < hits; i++)
            for (int j = i; j > 0; j--)
                if (kf[ord[j]] < kf[ord[j-1]] ||
                    (kf[ord[j]] == kf[ord[j-1]] && ks[ord[j]] < ks[ord[j-1]])) begin
                    tmp = ord[j]; ord[j] = ord[j-1]; ord[j-1] = tmp;
                end
        for (int i = 0; i < hits; i++) begin
            a.idx = ord[i][3:0];
            a.ans = '0;
            a.stat = STAT_OK;
            a.last = (i == hits - 1);
            if (sh_fnull[ord[i]]) a.stat = STAT_NULL;
            else if (sh_frac[ord[i]] > Q16_ONE) a.stat = STAT_RANGE;
            else if (sh_rows == 0) a.stat = STAT_NULL;
            else if (!sh_mode) begin
                if (dnull) a.stat = STAT_NULL; else a.ans = val;
            end else if (ks[ord[i]] > kf[ord[i]]) begin
                if (dnull || sh_held_null) a.stat = STAT_NULL_DATA;
                else begin
                    lo = longint'(signed'(sh_held));
                    hi = longint'(signed'(val));
                    lo = lo + (((hi - lo) * longint'(kp[ord[i]])) >>> 16);
                    a.ans = lo[31:0];
                end
            end else begin
                if (dnull) a.stat = STAT_NULL_DATA; else a.ans = val;
            end
            got.push_back(a);
        end
        sh_seen = r;
        sh_held = val;
        sh_held_null = dnull;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [20:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            CFG_MODE: sh_mode = value[0];
            CFG_ROWS: sh_rows = (value > ROW_SAT) ? ROW_SAT : value;
            CFG_REQS: sh_reqs = value[4:0];
            default: ;
        endcase
    endtask

    // registers change only once every answer is out and the scan has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send_item(input logic op, input logic [16:0] frac, input logic fnull,
                             input logic [31:0] val, input logic dnull,
                             input logic typed, input answer_t want);
        int      pct;
        answer_t got[$];
        pct = (phase == 1) ? 53 : (phase == 3) ? 8 : 0;
        while ($urandom_range(0, 99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, val, frac};
        s_tuser <= {dnull, fnull, op};
        do @(posedge aclk); while (!s_tready);
        predict_answers(op, frac, fnull, val, dnull, got);
        if (typed) pending_answers.push_back(want);
        else foreach (got[i]) pending_answers.push_back(got[i]);
    endtask

    // result side: random stalls per phase, compare against oldest expectation
    always @(posedge aclk) begin
        int pct;
        pct = (phase == 2) ? 53 : (phase == 3) ? 8 : 0;
        m_tready <= ($urandom_range(0, 99) >= pct);
    end

    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result idx=%0d ans=%0d status=%0d last=%0b",
                         $time, m_tdata[3:0], $signed(m_tdata[35:4]), m_tdata[37:36], m_tlast);
                failed = 1'b1;
            end else begin
                e = pending_answers.pop_front();
                if (e.idx !== m_tdata[3:0] || e.ans !== m_tdata[35:4] ||
                    e.stat !== m_tdata[37:36] || e.last !== m_tlast || m_tdata[47:38] !== '0) begin
                    $display("%0t: mismatch expected idx=%0d ans=%0d status=%0d last=%0b",
                             $time, e.idx, $signed(e.ans), e.stat, e.last);
                    $display("%0t:          actual   idx=%0d ans=%0d status=%0d last=%0b",
                             $time, m_tdata[3:0], $signed(m_tdata[35:4]), m_tdata[37:36],
                             m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: too long with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("multi_percentile_stream_selector_unit_test failed");
            $finish;
        end
    end

    function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [20:0] value);
        stim_row_t t;
        t = '{kind: ROW_CFG, default: '0};
        t.addr = addr; t.cfg_val = value;
        return t;
    endfunction

    function automatic stim_row_t item_row(input logic op, input logic [16:0] frac,
                                           input logic fnull, input logic [31:0] val,
                                           input logic dnull);
        stim_row_t t;
        t = '{kind: ROW_ITEM, default: '0};
        t.op = op; t.frac = frac; t.fnull = fnull;
        t.val = val; t.dnull = dnull;
        return t;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t t, input logic [3:0] idx,
                                            input logic [31:0] ans, input logic [1:0] stat);
        t.typed = 1'b1;
        t.want = '{idx: idx, ans: ans, stat: stat, last: 1'b1};
        return t;
    endfunction

    initial begin
        stim_row_t  dir_rows[$];
        int         sent, lim, nload, ndata, c;
        int         vals[$];
        logic [20:0] rows_pick;
        logic [4:0]  reqs_pick;
        logic [16:0] fr;
        bit          keep_stream;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // discrete: floor of one row, full scale, null, out of range, middle
        dir_rows.push_back(cfg_row(CFG_MODE, 21'd0));
        dir_rows.push_back(cfg_row(CFG_ROWS, 21'd4));
        dir_rows.push_back(cfg_row(CFG_REQS, 21'd5));
        dir_rows.push_back(item_row(OP_LOAD, 17'd0, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, Q16_ONE, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, 17'd0, 1'b1, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, 17'h1FFFF, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, 17'd32768, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, 17'd99, 1'b0, '0, 1'b0));  // beyond the count
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'h8000_0000, 1'b0));
        dir_rows.push_back(typed_row(item_row(OP_DATA, '0, 1'b0, 32'd5, 1'b1),
                                     4'd4, '0, STAT_NULL));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'd7, 1'b0));
        dir_rows.push_back(typed_row(item_row(OP_DATA, '0, 1'b0, 32'h7FFF_FFFF, 1'b0),
                                     4'd1, 32'h7FFF_FFFF, STAT_OK));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'hFFFF_FFFF, 1'b0));  // extra data
        // continuous: exact row, interpolated pair, top row
        dir_rows.push_back(cfg_row(CFG_MODE, 21'd1));
        dir_rows.push_back(cfg_row(CFG_ROWS, 21'd3));
        dir_rows.push_back(cfg_row(CFG_REQS, 21'd3));
        dir_rows.push_back(item_row(OP_LOAD, 17'd32768, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, 17'd16384, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_LOAD, Q16_ONE, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'd100, 1'b0));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'd200, 1'b0));
        dir_rows.push_back(typed_row(item_row(OP_DATA, '0, 1'b0, 32'd300, 1'b0),
                                     4'd2, 32'd300, STAT_OK));
        // new batch: interpolation with a null low row
        dir_rows.push_back(item_row(OP_LOAD, 17'd16384, 1'b0, '0, 1'b0));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'd1, 1'b1));
        dir_rows.push_back(typed_row(item_row(OP_DATA, '0, 1'b0, 32'd9, 1'b0),
                                     4'd0, '0, STAT_NULL_DATA));
        // zero rows, request count above the table size, saturated row count
        dir_rows.push_back(cfg_row(CFG_ROWS, 21'd0));
        dir_rows.push_back(cfg_row(CFG_REQS, 21'd31));
        dir_rows.push_back(item_row(OP_LOAD, 17'd0, 1'b0, '0, 1'b0));
        dir_rows.push_back(typed_row(item_row(OP_DATA, '0, 1'b0, 32'd3, 1'b0),
                                     4'd0, '0, STAT_NULL));
        dir_rows.push_back(item_row(OP_DATA, '0, 1'b0, 32'd4, 1'b0));
        dir_rows.push_back(cfg_row(CFG_ROWS, 21'h1F_FFFF));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].addr, dir_rows[i].cfg_val);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].frac, dir_rows[i].fnull,
                          dir_rows[i].val, dir_rows[i].dnull, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        // random batches: mostly well formed load-then-data runs
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = (sent * 4) / RANDOM_ITEMS;
            wait_idle();
            c = $urandom_range(0, 19);
            rows_pick = (c == 0) ? 21'd0 : (c == 1) ? 21'd40 : (c == 2) ? 21'(ROW_SAT) :
                        (c == 3) ? 21'h1F_FFFF : 21'($urandom_range(1, 10));
            reqs_pick = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) :
                                                       5'($urandom_range(0, 16));
            write_reg(CFG_MODE, 21'($urandom_range(0, 1)));
            write_reg(CFG_ROWS, rows_pick);
            write_reg(CFG_REQS, 21'(reqs_pick));
            // sometimes keep streaming the old batch under the new settings
            keep_stream = ($urandom_range(0, 4) == 0);
            if (!keep_stream) begin
                lim = (reqs_pick < MAX_REQ) ? reqs_pick : MAX_REQ;
                nload = lim + $urandom_range(0, 2);
                for (int i = 0; i < nload; i++) begin
                    c = $urandom_range(0, 15);
                    fr = (c == 0) ? 17'd0 : (c == 1) ? Q16_ONE :
                         (c == 2) ? 17'($urandom_range(65537, 131071)) :
                         (c == 3) ? 17'h1FFFF : 17'($urandom_range(0, 65536));
                    send_item(OP_LOAD, fr, ($urandom_range(0, 7) == 0),
                              $urandom, $urandom_range(0, 1), 1'b0, '{default: '0});
                    sent++;
                end
            end
            ndata = (rows_pick == 0) ? $urandom_range(1, 3) :
                    ((rows_pick > 12) ? 12 : rows_pick) + $urandom_range(0, 2);
            vals.delete();
            for (int i = 0; i < ndata; i++)
                vals.push_back(($urandom_range(0, 1)) ? int'($urandom) :
                                                         $urandom_range(0, 2000) - 1000);
            if ($urandom_range(0, 5) != 0) vals.sort();
            foreach (vals[i]) begin
                send_item(OP_DATA, 17'($urandom), $urandom_range(0, 1), vals[i],
                          ($urandom_range(0, 9) == 0), 1'b0, '{default: '0});
                sent++;
            end
        end

        phase = 0;
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (!failed)
            $display("multi_percentile_stream_selector_unit_test passed");
        else
            $display("multi_percentile_stream_selector_unit_test failed");
        $finish;
    end

endmodule

`default_nettype wire

### multi_percentile_stream_selector_unit.f
+incdir+design
design/mpss_pkg.sv
design/mpss_ctrl.sv
design/mpss_datapath.sv
design/multi_percentile_stream_selector_unit.sv
tb/multi_percentile_stream_selector_unit_test.sv
